### hw/rtl/bba_pkg.sv
// Shared codes, types and records for the buddy block allocator.
package bba_pkg;

	// Tree node codes
	typedef enum logic [1:0] {
		NODE_ABSENT = 2'd0,
		NODE_FREE   = 2'd1,
		NODE_SPLIT  = 2'd2,
		NODE_USED   = 2'd3
	} node_t;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_NO_OWNER = 2'd2;

	// Widths of order values (k, depth) inside the datapath
	localparam int unsigned KW = 5;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_EX_RD,
		ST_EX_CHK,
		ST_LV_RD,
		ST_LV_CHK,
		ST_SPLIT,
		ST_SPLIT_R,
		ST_MARK,
		ST_FR_RD,
		ST_FR_CHK,
		ST_MG_RD,
		ST_MG_CHK,
		ST_MG_W2,
		ST_MG_W3,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_EX_RD,
		OP_EX_TAKE,
		OP_EX_NEXT,
		OP_LV_START,
		OP_LV_RD,
		OP_LV_STEP,
		OP_LV_TAKE,
		OP_FAIL_SIZE,
		OP_SPLIT_W,
		OP_SPLIT_R,
		OP_MARK,
		OP_FR_RD,
		OP_FR_HIT,
		OP_FR_NEXT,
		OP_FAIL_OWNER,
		OP_MG_RD,
		OP_MG_W1,
		OP_MG_W2,
		OP_MG_W3
	} dp_op_t;

	typedef struct packed {
		logic is_free;
		logic k_over;
		logic d_zero;
		logic node_free;
		logic ex_last;
		logic lv_last;
		logic dd_last;
		logic found_any;
		logic split_more;
		logic slot_hit;
		logic slot_last;
		logic node_root;
		logic clr_last;
	} dp_status_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] offset;
		logic [3:0] order;
	} result_t;

endpackage

### hw/rtl/bba_dp.sv
// Datapath: node tree memory, owner slot memory, scan counters and result.
module bba_dp import bba_pkg::*; #(
	parameter int unsigned POOL_LOG2      = 10,
	parameter int unsigned MIN_BLOCK_LOG2 = 1,
	parameter int unsigned OWNER_BITS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_op_t      op,
	input  logic        act,
	input  logic [10:0] size,
	input  logic [7:0]  tag,
	output dp_status_t  st,
	output result_t     res
);

	localparam int unsigned NB         = POOL_LOG2 - MIN_BLOCK_LOG2 + 1;
	localparam int unsigned SB         = POOL_LOG2 - MIN_BLOCK_LOG2;
	localparam int unsigned NODE_COUNT = (1 << NB) - 1;
	localparam int unsigned SLOT_COUNT = 1 << SB;
	localparam int unsigned OFF_W      = POOL_LOG2;
	localparam int unsigned OW         = (OWNER_BITS < 8) ? OWNER_BITS : 8;
	localparam int unsigned SW         = 1 + KW + OW;
	localparam logic [KW-1:0] K_MIN    = KW'(MIN_BLOCK_LOG2);
	localparam logic [KW-1:0] K_MAX    = KW'(POOL_LOG2);

	function automatic logic [NB-1:0] base(input logic [KW-1:0] x);
		return NB'((32'd1 << x) - 32'd1);
	endfunction

	function automatic logic [9:0] to_off10(input logic [OFF_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[9:0];
	endfunction

	node_t           nmem [NODE_COUNT];
	logic [SW-1:0]   smem [SLOT_COUNT];
	node_t           nrd_q;
	logic [SW-1:0]   srd_q;

	logic [NB-1:0]    cnt_q;
	logic             found_q;
	logic             act_q;
	logic             kover_q;
	logic [KW-1:0]    k_q, d_q, dd_q, best_dd_q;
	logic [OW-1:0]    tag_q;
	logic [NB-1:0]    node_q, best_node_q;
	logic [OFF_W-1:0] best_off_q;
	result_t          res_q;

	logic [KW-1:0]    k_c;
	logic             kover_c;
	logic [NB-1:0]    ex_node, lv_node, buddy, parent, left, right;
	logic [NB-1:0]    mark_pos, fr_node;
	logic [OFF_W-1:0] lv_off, mark_off, fr_off;
	logic [SB-1:0]    mark_slot;
	logic [KW-1:0]    fr_raw, fr_k;
	logic             take;
	logic             nwe, swe;
	logic [NB-1:0]    nwa, nra;
	node_t            nwd;
	logic [SB-1:0]    swa;
	logic [SW-1:0]    swd;

	// Smallest order k in range whose block covers the size
	always_comb begin
		k_c     = K_MAX;
		kover_c = 1'b1;
		for (int j = POOL_LOG2; j >= int'(MIN_BLOCK_LOG2); j--) begin
			if ((33'd1 << j) >= 33'(size)) begin
				k_c     = KW'(j);
				kover_c = 1'b0;
			end
		end
	end

	always_comb begin
		ex_node   = base(d_q) + cnt_q;
		lv_node   = base(dd_q) + cnt_q;
		lv_off    = OFF_W'(cnt_q) << (K_MAX - dd_q);
		take      = (nrd_q == NODE_FREE) && (!found_q || lv_off < best_off_q);
		buddy     = node_q[0] ? node_q + NB'(1) : node_q - NB'(1);
		parent    = (node_q - NB'(1)) >> 1;
		left      = NB'(({1'b0, node_q} << 1) + (NB+1)'(1));
		right     = NB'(({1'b0, node_q} << 1) + (NB+1)'(2));
		mark_pos  = node_q - base(d_q);
		mark_off  = OFF_W'(mark_pos) << k_q;
		mark_slot = SB'(mark_off >> MIN_BLOCK_LOG2);
		fr_raw    = srd_q[SW-2 -: KW];
		fr_k      = (fr_raw < K_MIN || fr_raw > K_MAX) ? K_MIN : fr_raw;
		fr_off    = OFF_W'(cnt_q[SB-1:0]) << MIN_BLOCK_LOG2;
		fr_node   = base(K_MAX - fr_k) + NB'(fr_off >> fr_k);
	end

	// Memory port selection
	always_comb begin
		nwe = 1'b0;
		nwa = node_q;
		nwd = NODE_FREE;
		nra = buddy;
		swe = 1'b0;
		swa = cnt_q[SB-1:0];
		swd = {1'b0, k_q, tag_q};
		unique case (op)
			OP_CLEAR: begin
				nwe = 1'b1;
				nwa = cnt_q;
				nwd = (cnt_q == '0) ? NODE_FREE : NODE_ABSENT;
				swe = (cnt_q < NB'(SLOT_COUNT));
			end
			OP_EX_RD:  nra = ex_node;
			OP_LV_RD:  nra = lv_node;
			OP_SPLIT_W: begin
				nwe = 1'b1;
				nwd = NODE_SPLIT;
			end
			OP_SPLIT_R: begin
				nwe = 1'b1;
				nwa = right;
			end
			OP_MARK: begin
				nwe = 1'b1;
				nwd = NODE_USED;
				swe = 1'b1;
				swa = mark_slot;
				swd = {1'b1, k_q, tag_q};
			end
			OP_FR_HIT: begin
				nwe = 1'b1;
				nwa = fr_node;
				swe = 1'b1;
				swd = {1'b0, fr_k, tag_q};
			end
			OP_MG_W1: begin
				nwe = 1'b1;
				nwd = NODE_ABSENT;
			end
			OP_MG_W2: begin
				nwe = 1'b1;
				nwa = buddy;
				nwd = NODE_ABSENT;
			end
			OP_MG_W3: begin
				nwe = 1'b1;
				nwa = parent;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nwe)
			nmem[nwa] <= nwd;
		nrd_q <= nmem[nra];
	end

	always_ff @(posedge clk) begin
		if (swe)
			smem[swa] <= swd;
		srd_q <= smem[cnt_q[SB-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (op) inside
				OP_CLEAR, OP_EX_NEXT, OP_FR_NEXT: cnt_q <= cnt_q + NB'(1);
				OP_LOAD: cnt_q <= '0;
				OP_LV_START: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
				end
				OP_LV_STEP: begin
					cnt_q <= st.lv_last ? '0 : cnt_q + NB'(1);
					if (take)
						found_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				act_q   <= act;
				tag_q   <= tag[OW-1:0];
				k_q     <= k_c;
				kover_q <= kover_c;
				d_q     <= K_MAX - k_c;
			end
			OP_EX_TAKE: node_q <= ex_node;
			OP_LV_START: dd_q <= '0;
			OP_LV_STEP: begin
				if (take) begin
					best_off_q  <= lv_off;
					best_node_q <= lv_node;
					best_dd_q   <= dd_q;
				end
				if (st.lv_last)
					dd_q <= dd_q + KW'(1);
			end
			OP_LV_TAKE: begin
				node_q <= take ? lv_node : best_node_q;
				dd_q   <= take ? dd_q : best_dd_q;
			end
			OP_SPLIT_R: begin
				node_q <= left;
				dd_q   <= dd_q + KW'(1);
			end
			OP_MARK: res_q <= '{status: ST_OK, offset: to_off10(mark_off), order: k_q[3:0]};
			OP_FR_HIT: begin
				node_q <= fr_node;
				res_q  <= '{status: ST_OK, offset: to_off10(fr_off), order: fr_k[3:0]};
			end
			OP_MG_W3: node_q <= parent;
			OP_FAIL_SIZE: res_q <= '{status: ST_NO_SPACE, offset: '0, order: '0};
			OP_FAIL_OWNER: res_q <= '{status: ST_NO_OWNER, offset: '0, order: '0};
			default: ;
		endcase
	end

	always_comb begin
		st.is_free    = act_q;
		st.k_over     = kover_q;
		st.d_zero     = (d_q == '0);
		st.node_free  = (nrd_q == NODE_FREE);
		st.ex_last    = (cnt_q == base(d_q));
		st.lv_last    = (cnt_q == base(dd_q));
		st.dd_last    = (dd_q == d_q - KW'(1));
		st.found_any  = found_q || take;
		st.split_more = (dd_q < d_q);
		st.slot_hit   = srd_q[SW-1] && (srd_q[OW-1:0] == tag_q);
		st.slot_last  = (cnt_q == NB'(SLOT_COUNT - 1));
		st.node_root  = (node_q == '0);
		st.clr_last   = (cnt_q == NB'(NODE_COUNT - 1));
	end

	assign res = res_q;

endmodule

### hw/rtl/bba_ctrl.sv
// Controller: sequences clearing, allocate scans, splits, free search and merges.
module bba_ctrl import bba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_free,
	output logic       out_load,
	input  dp_status_t st,
	output dp_op_t     op
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				op = OP_CLEAR;
				if (st.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (st.is_free)
					state_d = ST_FR_RD;
				else if (st.k_over) begin
					op      = OP_FAIL_SIZE;
					state_d = ST_DONE;
				end else
					state_d = ST_EX_RD;
			end
			ST_EX_RD: begin
				op      = OP_EX_RD;
				state_d = ST_EX_CHK;
			end
			ST_EX_CHK: begin
				if (st.node_free) begin
					op      = OP_EX_TAKE;
					state_d = ST_MARK;
				end else if (st.ex_last) begin
					if (st.d_zero) begin
						op      = OP_FAIL_SIZE;
						state_d = ST_DONE;
					end else begin
						op      = OP_LV_START;
						state_d = ST_LV_RD;
					end
				end else begin
					op      = OP_EX_NEXT;
					state_d = ST_EX_RD;
				end
			end
			ST_LV_RD: begin
				op      = OP_LV_RD;
				state_d = ST_LV_CHK;
			end
			ST_LV_CHK: begin
				if (st.lv_last && st.dd_last) begin
					if (st.found_any) begin
						op      = OP_LV_TAKE;
						state_d = ST_SPLIT;
					end else begin
						op      = OP_FAIL_SIZE;
						state_d = ST_DONE;
					end
				end else begin
					op      = OP_LV_STEP;
					state_d = ST_LV_RD;
				end
			end
			ST_SPLIT: begin
				if (st.split_more) begin
					op      = OP_SPLIT_W;
					state_d = ST_SPLIT_R;
				end else
					state_d = ST_MARK;
			end
			ST_SPLIT_R: begin
				op      = OP_SPLIT_R;
				state_d = ST_SPLIT;
			end
			ST_MARK: begin
				op      = OP_MARK;
				state_d = ST_DONE;
			end
			ST_FR_RD: begin
				op      = OP_FR_RD;
				state_d = ST_FR_CHK;
			end
			ST_FR_CHK: begin
				if (st.slot_hit) begin
					op      = OP_FR_HIT;
					state_d = ST_MG_RD;
				end else if (st.slot_last) begin
					op      = OP_FAIL_OWNER;
					state_d = ST_DONE;
				end else begin
					op      = OP_FR_NEXT;
					state_d = ST_FR_RD;
				end
			end
			ST_MG_RD: begin
				if (st.node_root)
					state_d = ST_DONE;
				else begin
					op      = OP_MG_RD;
					state_d = ST_MG_CHK;
				end
			end
			ST_MG_CHK: begin
				if (st.node_free) begin
					op      = OP_MG_W1;
					state_d = ST_MG_W2;
				end else
					state_d = ST_DONE;
			end
			ST_MG_W2: begin
				op      = OP_MG_W2;
				state_d = ST_MG_W3;
			end
			ST_MG_W3: begin
				op      = OP_MG_W3;
				state_d = ST_MG_RD;
			end
			ST_DONE: begin
				// hold the result until the output register frees up
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

### hw/rtl/buddy_block_allocator.sv
// Buddy block allocator: request stream in, one result beat out per request.
//
// Input beats (s_axis_*): tuser selects allocate (0) or free (1); tdata carries
// the request size and the owner tag. Output beats (m_axis_*): tuser is the
// status, tdata the block offset and order.
// After reset the block sweeps its node and slot memories, one entry a cycle,
// over all 2^(POOL_LOG2-MIN_BLOCK_LOG2+1)-1 node entries (1023 by default);
// s_axis_tready stays low until the sweep ends. One request is worked at a
// time; each memory read is registered and has its own read state before the
// check. Allocate: scan the exact-size level node by node (up to 2^d nodes),
// then, when no exact block is free, every node of the larger levels, then
// split level by level down to the exact size. Free: scan the owner slots (up
// to 512), then merge level by level. The node memory's single read port
// makes every scan step a read followed by a check.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next finished result holds in the
// controller until the register empties.
module buddy_block_allocator import bba_pkg::*; #(
	parameter int unsigned POOL_LOG2      = 10,
	parameter int unsigned MIN_BLOCK_LOG2 = 1,
	parameter int unsigned OWNER_BITS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // request_size[10:0], owner_tag[18:11]
	input  logic        s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // block_offset[9:0], block_order[13:10]
	output logic [1:0]  m_axis_tuser    // status
);

	dp_op_t     op;
	dp_status_t st;
	result_t    res;
	result_t    out_q;
	logic       out_valid_q;
	logic       out_load;
	logic       out_free;

	assign out_free = !out_valid_q || m_axis_tready;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.out_load (out_load),
		.st       (st),
		.op       (op)
	);

	bba_dp #(
		.POOL_LOG2      (POOL_LOG2),
		.MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
		.OWNER_BITS     (OWNER_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.act    (s_axis_tuser),
		.size   (s_axis_tdata[10:0]),
		.tag    (s_axis_tdata[18:11]),
		.st     (st),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.order, out_q.offset};
	assign m_axis_tuser  = out_q.status;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
		else $error("error beat carries nonzero offset or order");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result loaded over an untaken beat");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_NO_SPACE ||
			m_axis_tuser == ST_NO_OWNER))
		else $error("undefined status code");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !s_axis_tready)
		else $error("input ready while a result is being issued");
`endif

endmodule

### tb/tb_top.sv
// Self-checking stream testbench for the buddy block allocator.
`timescale 1ns / 100ps

module tb_top import bba_pkg::*; ();

	localparam int POOL_LOG2  = 10;
	localparam int MIN_LOG2   = 1;
	localparam int DEPTHS     = POOL_LOG2 - MIN_LOG2 + 1;
	localparam int NODES      = (1 << DEPTHS) - 1;
	localparam int SLOTS      = 1 << (POOL_LOG2 - MIN_LOG2);
	localparam int IDLE_LIMIT = 20000;
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef struct packed {
		logic        action;
		logic [10:0] size;
		logic [7:0]  owner;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	buddy_block_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Predictor state: buddy tree and per-slot owner records
	node_t      tree[NODES];
	logic [7:0] owner_of[SLOTS];
	logic [3:0] order_of[SLOTS];
	logic       held[SLOTS];

	request_t pending_reqs[$];
	result_t  expected_results[$];
	int       errors = 0;
	int       n_done = 0, n_no_space = 0, n_no_owner = 0;
	bit       hold_sender = 0;
	bit       stim_done = 0;

	function automatic result_t buddy_predict(request_t r);
		result_t    res;
		int         k, d, node, bd, bp, s, buddy;
		bit         found;
		logic [10:0] off;
		res = '0;
		if (r.action == ACT_FREE) begin
			for (s = 0; s < SLOTS; s++)
				if (held[s] && owner_of[s] == r.owner) break;
			if (s >= SLOTS) begin
				res.status = ST_NO_OWNER;
				return res;
			end
			k = int'(order_of[s]);
			off = 11'(s << MIN_LOG2);
			d = POOL_LOG2 - k;
			node = (1 << d) - 1 + int'(off >> k);
			held[s] = 0;
			tree[node] = NODE_FREE;
			while (node > 0) begin
				buddy = (node & 1) ? node + 1 : node - 1;
				if (tree[buddy] != NODE_FREE) break;
				tree[node] = NODE_ABSENT;
				tree[buddy] = NODE_ABSENT;
				node = (node - 1) / 2;
				tree[node] = NODE_FREE;
			end
			res.status = ST_OK;
			res.offset = off[9:0];
			res.order = k[3:0];
			return res;
		end
		k = MIN_LOG2;
		while (k <= POOL_LOG2 && (1 << k) < r.size) k++;
		if (k > POOL_LOG2) begin
			res.status = ST_NO_SPACE;
			return res;
		end
		d = POOL_LOG2 - k;
		found = 0;
		for (int p = 0; p < (1 << d); p++)
			if (!found && tree[(1 << d) - 1 + p] == NODE_FREE) begin
				node = (1 << d) - 1 + p;
				found = 1;
			end
		if (!found) begin
			int best_off;
			best_off = 0;
			for (int dd = 0; dd < d; dd++)
				for (int p = 0; p < (1 << dd); p++)
					if (tree[(1 << dd) - 1 + p] == NODE_FREE &&
					    (!found || (p << (POOL_LOG2 - dd)) < best_off)) begin
						found = 1;
						best_off = p << (POOL_LOG2 - dd);
						bd = dd;
						bp = p;
					end
			if (!found) begin
				res.status = ST_NO_SPACE;
				return res;
			end
			node = (1 << bd) - 1 + bp;
			while (bd < d) begin
				tree[node] = NODE_SPLIT;
				tree[2 * node + 1] = NODE_FREE;
				tree[2 * node + 2] = NODE_FREE;
				node = 2 * node + 1;
				bd++;
			end
		end
		tree[node] = NODE_USED;
		off = 11'((node - ((1 << d) - 1)) << k);
		s = int'(off >> MIN_LOG2);
		held[s] = 1;
		owner_of[s] = r.owner;
		order_of[s] = k[3:0];
		res.status = ST_OK;
		res.offset = off[9:0];
		res.order = k[3:0];
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Driver: bursts of beats separated by random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				r = pending_reqs.pop_front();
				expected_results.insert(expected_results.size(), buddy_predict(r));
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !hold_sender) begin
					r = pending_reqs[0];
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'd0, r.owner, r.size};
					s_axis_tuser <= r.action;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
					end
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: alternating phases of steady and sparse readiness
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			stall_phase = (stall_phase + 1) % 600;
			if (stall_phase < 200) m_axis_tready <= 1'b1;
			else if (stall_phase < 400) m_axis_tready <= ($urandom_range(0, 3) == 0);
			else m_axis_tready <= ($urandom_range(0, 1) == 0);
		end
	end

	// Monitor: compare each result beat with the oldest expectation
	int idle_cycles = 0;
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat status=%0d", m_axis_tuser);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (m_axis_tuser != exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[9:0] != exp_r.offset) begin
						$error("block_offset exp %0d got %0d", exp_r.offset, m_axis_tdata[9:0]);
						errors++;
					end
					if (m_axis_tdata[13:10] != exp_r.order) begin
						$error("block_order exp %0d got %0d", exp_r.order, m_axis_tdata[13:10]);
						errors++;
					end
					case (exp_r.status)
						ST_NO_SPACE: n_no_space++;
						ST_NO_OWNER: n_no_owner++;
						default: n_done++;
					endcase
				end
			end
		end
	end

	function automatic request_t mk(logic act, int size, int owner);
		request_t r;
		r.action = act;
		r.size = size[10:0];
		r.owner = owner[7:0];
		return r;
	endfunction

	function automatic void queue_req(request_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	initial begin
		int live_tags[$];
		int idx, t;
		arst_n = 1'b0;
		tree[0] = NODE_FREE;
		for (int n = 1; n < NODES; n++) tree[n] = NODE_ABSENT;
		for (int s = 0; s < SLOTS; s++) begin
			held[s] = 0;
			owner_of[s] = '0;
			order_of[s] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: whole pool, oversize, zero size, unknown owner, duplicates, merges
		queue_req(mk(ACT_ALLOC, 1024, 8'hFF));
		queue_req(mk(ACT_ALLOC, 1, 1));
		queue_req(mk(ACT_FREE, 2047, 8'hFF));
		queue_req(mk(ACT_ALLOC, 1025, 2));
		queue_req(mk(ACT_ALLOC, 2047, 3));
		queue_req(mk(ACT_ALLOC, 0, 0));
		queue_req(mk(ACT_ALLOC, 1, 7));
		queue_req(mk(ACT_ALLOC, 3, 7));
		queue_req(mk(ACT_ALLOC, 513, 9));
		queue_req(mk(ACT_ALLOC, 512, 10));
		queue_req(mk(ACT_FREE, 0, 200));
		queue_req(mk(ACT_FREE, 5, 7));
		queue_req(mk(ACT_FREE, 0, 0));
		queue_req(mk(ACT_FREE, 0, 7));
		queue_req(mk(ACT_FREE, 0, 7));
		queue_req(mk(ACT_FREE, 0, 10));
		queue_req(mk(ACT_ALLOC, 256, 8'hAA));
		queue_req(mk(ACT_ALLOC, 128, 8'h55));
		queue_req(mk(ACT_FREE, 0, 8'hAA));
		queue_req(mk(ACT_FREE, 0, 8'h55));

		// Let every directed result drain before the random part
		wait (pending_reqs.size() == 0);
		hold_sender = 1;
		wait (expected_results.size() == 0);
		hold_sender = 0;

		// Random: mostly allocs of live tags then frees, some noise
		for (int i = 0; i < 2000; i++) begin
			if (live_tags.size() > 0 && ($urandom_range(0, 99) < 45)) begin
				idx = $urandom_range(0, live_tags.size() - 1);
				t = live_tags[idx];
				live_tags.delete(idx);
				queue_req(mk(ACT_FREE, $urandom_range(0, 2047), t));
			end else if ($urandom_range(0, 19) == 0) begin
				queue_req(mk(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
				             $urandom_range(0, 255)));
			end else begin
				t = $urandom_range(0, 255);
				live_tags.insert(live_tags.size(), t);
				case ($urandom_range(0, 9))
					0: queue_req(mk(ACT_ALLOC, $urandom_range(1, 1024), t));
					1: queue_req(mk(ACT_ALLOC, $urandom_range(0, 2047), t));
					default: queue_req(mk(ACT_ALLOC, $urandom_range(1, 64), t));
				endcase
			end
		end
		while (live_tags.size() > 0) begin
			queue_req(mk(ACT_FREE, 0, live_tags.pop_front()));
		end

		wait (pending_reqs.size() == 0);
		wait (expected_results.size() == 0);
		repeat (3000) @(posedge clk);
		$display("Covered directed extremes and random alloc/free traffic with bursty input");
		$display("and patterned output stalls: %0d done, %0d no-space, %0d no-owner.",
		         n_done, n_no_space, n_no_owner);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

### sim.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_dp.sv
hw/rtl/bba_ctrl.sv
hw/rtl/buddy_block_allocator.sv
tb/tb_top.sv
